### hw/rtl/iepc_pkg.sv
package iepc_pkg;

    localparam int PAGE_BYTES   = 8;
    localparam int MEMORY_BYTES = 256;

    localparam logic [4:0] PH_IDLE      = 5'd0;
    localparam logic [4:0] PH_START_HI  = 5'd1;
    localparam logic [4:0] PH_START_LO  = 5'd2;
    localparam logic [4:0] PH_TX_LOW    = 5'd3;
    localparam logic [4:0] PH_TX_HIGH   = 5'd4;
    localparam logic [4:0] PH_ACK_LOW   = 5'd5;
    localparam logic [4:0] PH_ACK_HIGH  = 5'd6;
    localparam logic [4:0] PH_RS_LOW    = 5'd7;
    localparam logic [4:0] PH_RX_LOW    = 5'd8;
    localparam logic [4:0] PH_RX_HIGH   = 5'd9;
    localparam logic [4:0] PH_MACK_LOW  = 5'd10;
    localparam logic [4:0] PH_MACK_HIGH = 5'd11;
    localparam logic [4:0] PH_STOP_A    = 5'd12;
    localparam logic [4:0] PH_STOP_B    = 5'd13;
    localparam logic [4:0] PH_STOP_C    = 5'd14;
    localparam logic [4:0] PH_WAIT      = 5'd15;

    localparam logic [1:0] ROLE_DEV_W = 2'd0;
    localparam logic [1:0] ROLE_WORD  = 2'd1;
    localparam logic [1:0] ROLE_DATA  = 2'd2;
    localparam logic [1:0] ROLE_DEV_R = 2'd3;

    localparam logic [1:0] KIND_TICK  = 2'd0;
    localparam logic [1:0] KIND_PUSH  = 2'd1;
    localparam logic [1:0] KIND_WRITE = 2'd2;
    localparam logic [1:0] KIND_READ  = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_NACK  = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;

    localparam logic [1:0] REG_HALF = 2'd0;
    localparam logic [1:0] REG_WAIT = 2'd1;
    localparam logic [1:0] REG_DEV  = 2'd2;

    typedef struct packed {
        logic [1:0] kind;
        logic       sda_sample;
        logic [7:0] start_address;
        logic [8:0] byte_count;
        logic [7:0] write_byte;
    } t_in;

    typedef struct packed {
        logic       scl_level;
        logic       sda_level;
        logic       read_valid;
        logic [7:0] read_byte;
        logic       busy_res;
        logic       done_res;
        logic [1:0] status;
    } t_out;

    // buffer write port / read address from the sequencer
    typedef struct packed {
        logic       we;
        logic [7:0] waddr;
        logic [7:0] wdata;
        logic [7:0] raddr;
    } t_buf_req;

endpackage

### hw/rtl/iepc_buffer.sv
module iepc_buffer import iepc_pkg::*; (
    input  logic       i_clk,
    input  t_buf_req   i_req,
    output logic [7:0] o_rdata
);

    logic [7:0] r_mem [256];

    // write pushed bytes, read one entry a cycle
    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        o_rdata <= r_mem[i_req.raddr];
    end

endmodule

### hw/rtl/iepc_seq.sv
module iepc_seq import iepc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_go,
    input  t_in         i_item,
    input  logic [15:0] i_half,
    input  logic [23:0] i_wait,
    input  logic [6:0]  i_dev,
    input  logic [7:0]  i_rdata,
    output t_buf_req    o_buf,
    output t_out        o_res
);

    logic [8:0]  r_fill, n_fill;
    logic [4:0]  r_ph, n_ph;
    logic [3:0]  r_bit, n_bit;
    logic [7:0]  r_sh, n_sh;
    logic [7:0]  r_addr, n_addr;
    logic [8:0]  r_left, n_left;
    logic [6:0]  r_page, n_page;
    logic [23:0] r_tick, n_tick;
    logic        r_rd, n_rd;
    logic [1:0]  r_role, n_role;
    logic [8:0]  r_pos, n_pos;
    logic [1:0]  r_err, n_err;
    logic        done, rvalid;
    logic [1:0]  st;
    logic [7:0]  rbyte;
    logic [23:0] dur, tinc;
    logic [8:0]  space, dleft;
    logic [6:0]  dpage;
    logic [9:0]  rsum;

    // prefetch the entry of the next data byte: r_pos until the first data byte,
    // one past r_pos while data bytes go out; r_pos is stable for a whole byte
    always_comb begin
        o_buf.we    = 1'b0;
        o_buf.waddr = r_fill[7:0];
        o_buf.wdata = i_item.write_byte;
        o_buf.raddr = r_pos[7:0] + {7'd0, (r_role == ROLE_DATA)};
        if (i_go && r_ph == PH_IDLE && i_item.kind == KIND_PUSH && !r_fill[8]) begin
            o_buf.we = 1'b1;
        end
    end

    // next state of the bus sequencer
    always_comb begin
        n_fill = r_fill; n_ph = r_ph; n_bit = r_bit; n_sh = r_sh; n_addr = r_addr;
        n_left = r_left; n_page = r_page; n_tick = r_tick; n_rd = r_rd; n_role = r_role;
        n_pos = r_pos; n_err = r_err;
        done = 1'b0; rvalid = 1'b0; st = ST_OK; rbyte = 8'd0;
        dur = (r_ph == PH_WAIT) ? i_wait : {8'd0, i_half};
        if (dur == 24'd0) dur = 24'd1;
        tinc = r_tick + 24'd1;
        space = 9'(PAGE_BYTES) - 9'(r_addr % PAGE_BYTES);
        dleft = (r_left != 9'd0) ? r_left - 9'd1 : 9'd0;
        dpage = (r_page != 7'd0) ? r_page - 7'd1 : 7'd0;
        rsum = {2'b00, i_item.start_address} + {1'b0, i_item.byte_count};
        if (i_go) begin
            if (i_item.kind == KIND_TICK) begin
                if (r_ph != PH_IDLE) begin
                    n_tick = tinc;
                    if (tinc >= dur) begin
                        n_tick = 24'd0;
                        case (r_ph)
                            PH_START_HI: n_ph = PH_START_LO;
                            PH_START_LO: begin
                                n_sh = {i_dev, (r_role == ROLE_DEV_R)};
                                n_bit = 4'd0; n_ph = PH_TX_LOW;
                            end
                            PH_TX_LOW: n_ph = PH_TX_HIGH;
                            PH_TX_HIGH: begin
                                if (r_bit >= 4'd7) begin
                                    n_ph = PH_ACK_LOW;
                                end else begin
                                    n_bit = r_bit + 4'd1;
                                    n_sh = {r_sh[6:0], 1'b0};
                                    n_ph = PH_TX_LOW;
                                end
                            end
                            PH_ACK_LOW: n_ph = PH_ACK_HIGH;
                            PH_ACK_HIGH: begin
                                if (i_item.sda_sample) begin
                                    n_err = ST_NACK; n_ph = PH_STOP_A;
                                end else if (r_role == ROLE_DEV_W) begin
                                    n_role = ROLE_WORD;
                                    n_sh = r_addr; n_bit = 4'd0; n_ph = PH_TX_LOW;
                                end else if (r_role == ROLE_WORD) begin
                                    if (r_rd) begin
                                        n_role = ROLE_DEV_R; n_ph = PH_RS_LOW;
                                    end else begin
                                        n_role = ROLE_DATA;
                                        n_sh = i_rdata; n_bit = 4'd0; n_ph = PH_TX_LOW;
                                    end
                                end else if (r_role == ROLE_DATA) begin
                                    n_pos = r_pos + 9'd1;
                                    n_addr = r_addr + 8'd1;
                                    n_left = dleft;
                                    n_page = dpage;
                                    if (dpage == 7'd0) n_ph = PH_STOP_A;
                                    else begin
                                        n_sh = i_rdata; n_bit = 4'd0; n_ph = PH_TX_LOW;
                                    end
                                end else begin
                                    if (r_left == 9'd0) n_ph = PH_STOP_A;
                                    else begin
                                        n_bit = 4'd0; n_sh = 8'd0; n_ph = PH_RX_LOW;
                                    end
                                end
                            end
                            PH_RS_LOW: n_ph = PH_START_HI;
                            PH_RX_LOW: n_ph = PH_RX_HIGH;
                            PH_RX_HIGH: begin
                                n_sh = {r_sh[6:0], i_item.sda_sample};
                                if (r_bit >= 4'd7) begin
                                    rvalid = 1'b1; rbyte = n_sh; n_ph = PH_MACK_LOW;
                                end else begin
                                    n_bit = r_bit + 4'd1; n_ph = PH_RX_LOW;
                                end
                            end
                            PH_MACK_LOW: n_ph = PH_MACK_HIGH;
                            PH_MACK_HIGH: begin
                                n_left = dleft;
                                n_addr = r_addr + 8'd1;
                                if (dleft == 9'd0) n_ph = PH_STOP_A;
                                else begin
                                    n_bit = 4'd0; n_sh = 8'd0; n_ph = PH_RX_LOW;
                                end
                            end
                            PH_STOP_A: n_ph = PH_STOP_B;
                            PH_STOP_B: n_ph = PH_STOP_C;
                            PH_STOP_C: begin
                                if (!r_rd && r_err == ST_OK) n_ph = PH_WAIT;
                                else begin
                                    n_ph = PH_IDLE; done = 1'b1; st = r_err;
                                end
                            end
                            PH_WAIT: begin
                                if (r_left == 9'd0) begin
                                    n_ph = PH_IDLE; done = 1'b1; st = ST_OK;
                                end else begin
                                    n_page = (r_left < space) ? r_left[6:0] : space[6:0];
                                    n_role = ROLE_DEV_W; n_ph = PH_START_HI;
                                end
                            end
                            default: n_ph = PH_IDLE;
                        endcase
                    end
                end
            end else if (r_ph == PH_IDLE && i_item.kind == KIND_PUSH) begin
                if (!r_fill[8]) n_fill = r_fill + 9'd1;
            end else if (r_ph == PH_IDLE) begin
                n_rd = (i_item.kind == KIND_READ);
                n_err = ST_OK; n_tick = 24'd0;
                n_addr = i_item.start_address;
                n_left = i_item.byte_count;
                n_role = ROLE_DEV_W; n_pos = 9'd0;
                space = 9'(PAGE_BYTES) - 9'(i_item.start_address % PAGE_BYTES);
                if (n_rd) begin
                    if (rsum > 10'(MEMORY_BYTES)) begin
                        done = 1'b1; st = ST_RANGE;
                    end else n_ph = PH_START_HI;
                end else begin
                    n_fill = 9'd0;
                    if (i_item.byte_count == 9'd0) begin
                        done = 1'b1; st = ST_OK;
                    end else begin
                        n_page = (i_item.byte_count < space) ? i_item.byte_count[6:0]
                                                             : space[6:0];
                        n_ph = PH_START_HI;
                    end
                end
            end
        end
        if (done) n_tick = 24'd0;
    end

    // drive lines from the next state
    always_comb begin
        o_res.scl_level = 1'b1;
        o_res.sda_level = 1'b1;
        case (n_ph)
            PH_START_LO: o_res.sda_level = 1'b0;
            PH_TX_LOW: begin o_res.scl_level = 1'b0; o_res.sda_level = n_sh[7]; end
            PH_TX_HIGH: o_res.sda_level = n_sh[7];
            PH_ACK_LOW, PH_RS_LOW, PH_RX_LOW: o_res.scl_level = 1'b0;
            PH_MACK_LOW: begin
                o_res.scl_level = 1'b0; o_res.sda_level = !(n_left > 9'd1);
            end
            PH_MACK_HIGH: o_res.sda_level = !(n_left > 9'd1);
            PH_STOP_A: begin o_res.scl_level = 1'b0; o_res.sda_level = 1'b0; end
            PH_STOP_B: o_res.sda_level = 1'b0;
            default: ;
        endcase
        o_res.read_valid = rvalid;
        o_res.read_byte  = rbyte;
        o_res.busy_res   = (n_ph != PH_IDLE);
        o_res.done_res   = done;
        o_res.status     = st;
    end

    // hold control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0; r_ph <= PH_IDLE; r_bit <= '0; r_sh <= '0; r_addr <= '0;
            r_left <= '0; r_page <= '0; r_tick <= '0; r_rd <= 1'b0;
            r_role <= ROLE_DEV_W; r_pos <= '0; r_err <= ST_OK;
        end else begin
            r_fill <= n_fill; r_ph <= n_ph; r_bit <= n_bit; r_sh <= n_sh;
            r_addr <= n_addr; r_left <= n_left; r_page <= n_page; r_tick <= n_tick;
            r_rd <= n_rd; r_role <= n_role; r_pos <= n_pos; r_err <= n_err;
        end
    end

endmodule

### hw/rtl/i2c_eeprom_page_controller.sv
// An accepted request's result is registered into the output register at the edge that accepts it.
// Throughput: one request per cycle while o_stall is low; the sequencer state is updated
// with each accepted request, and the buffer memory entry for the next data byte is prefetched.
// Reset: synchronous, active low; sequencer idle, buffer empty, registers at defaults.
// The write buffer memory is not cleared.
module i2c_eeprom_page_controller import iepc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  t_in         i_data,
    output logic        o_valid,
    input  logic        i_stall,
    output t_out        o_data,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [15:0] r_half;
    logic [23:0] r_wait;
    logic [6:0]  r_dev;
    logic        r_ov;
    logic        go;
    t_out        res;
    t_buf_req    breq;
    logic [7:0]  rdata;

    assign pready  = 1'b1;
    assign o_stall = r_ov && i_stall;
    assign go      = i_valid && !o_stall;
    assign o_valid = r_ov;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half <= 16'd60; r_wait <= 24'd6000; r_dev <= 7'd80;
        end else if (psel && penable && pwrite) begin
            case (paddr[3:2])
                REG_HALF: r_half <= pwdata[15:0];
                REG_WAIT: r_wait <= pwdata[23:0];
                REG_DEV:  r_dev  <= pwdata[6:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_HALF: prdata = {16'd0, r_half};
            REG_WAIT: prdata = {8'd0, r_wait};
            REG_DEV:  prdata = {25'd0, r_dev};
            default:  prdata = 32'd0;
        endcase
    end

    iepc_buffer u_buf (.i_clk(i_clk), .i_req(breq), .o_rdata(rdata));

    iepc_seq u_seq (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_go(go), .i_item(i_data),
        .i_half(r_half), .i_wait(r_wait), .i_dev(r_dev), .i_rdata(rdata),
        .o_buf(breq), .o_res(res)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_ov <= 1'b0;
        else if (go) r_ov <= 1'b1;
        else if (!i_stall) r_ov <= 1'b0;
        if (go) o_data <= res;
    end

endmodule

### dv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
    import iepc_pkg::*;

    // Queue entry modes: given as is, bus-responder data line, ticks until idle,
    // hold off until every expected result is in.
    localparam logic [1:0] M_FIXED = 2'd0;
    localparam logic [1:0] M_AUTO  = 2'd1;
    localparam logic [1:0] M_RUN   = 2'd2;
    localparam logic [1:0] M_HOLD  = 2'd3;

    typedef struct {
        t_in        req;
        logic [1:0] mode;
    } t_pending;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    t_in         i_data;
    logic        o_valid;
    logic        i_stall;
    t_out        o_data;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    i2c_eeprom_page_controller uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (o_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    t_pending pending_req[$];
    t_out     expected_res[$];
    int       fail_count;
    int       snd_idle_pct;
    int       rcv_idle_pct;
    bit       took;

    // Controller shadow state
    logic [15:0] c_half;
    logic [23:0] c_wait;
    logic [6:0]  c_dev;
    logic [7:0]  wbuf [256];
    int          fill;
    int          written_upto;
    logic [4:0]  ph;
    logic [3:0]  bidx;
    logic [7:0]  shreg;
    logic [7:0]  caddr;
    int          left;
    int          pleft;
    logic [23:0] tcnt;
    bit          rd_op;
    logic [1:0]  role;
    logic [8:0]  bpos;
    logic [1:0]  err;
    bit          p_done;
    logic [1:0]  p_st;
    bit          p_rv;
    logic [7:0]  p_rb;

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Run limit
    initial begin
        #4000000;
        $display("FAIL");
        $finish;
    end

    task automatic report(string field, logic [7:0] got, logic [7:0] want);
        $display("mismatch %s: got %0h expected %0h at %0t", field, got, want, $realtime);
        fail_count++;
    endtask

    task automatic load_page();
        int space;
        space = PAGE_BYTES - (caddr % PAGE_BYTES);
        pleft = (left < space) ? left : space;
    endtask

    task automatic send_byte(input logic [7:0] v);
        shreg = v;
        bidx = 4'd0;
        ph = PH_TX_LOW;
    endtask

    task automatic end_xfer(input logic [1:0] code);
        ph = PH_IDLE;
        tcnt = '0;
        p_done = 1'b1;
        p_st = code;
    endtask

    // Advance the bus sequence by one phase
    task automatic next_phase(input logic sample);
        case (ph)
            PH_START_HI: ph = PH_START_LO;
            PH_START_LO: send_byte({c_dev, role == ROLE_DEV_R});
            PH_TX_LOW: ph = PH_TX_HIGH;
            PH_TX_HIGH: begin
                if (bidx >= 4'd7) begin
                    ph = PH_ACK_LOW;
                end else begin
                    bidx++;
                    shreg = shreg << 1;
                    ph = PH_TX_LOW;
                end
            end
            PH_ACK_LOW: ph = PH_ACK_HIGH;
            PH_ACK_HIGH: begin
                if (sample) begin
                    err = ST_NACK;
                    ph = PH_STOP_A;
                end else if (role == ROLE_DEV_W) begin
                    role = ROLE_WORD;
                    send_byte(caddr);
                end else if (role == ROLE_WORD) begin
                    if (rd_op) begin
                        role = ROLE_DEV_R;
                        ph = PH_RS_LOW;
                    end else begin
                        role = ROLE_DATA;
                        send_byte(wbuf[bpos[7:0]]);
                    end
                end else if (role == ROLE_DATA) begin
                    bpos++;
                    caddr++;
                    if (left > 0) left--;
                    if (pleft > 0) pleft--;
                    if (pleft == 0) ph = PH_STOP_A;
                    else send_byte(wbuf[bpos[7:0]]);
                end else if (left == 0) begin
                    ph = PH_STOP_A;
                end else begin
                    bidx = 4'd0;
                    shreg = '0;
                    ph = PH_RX_LOW;
                end
            end
            PH_RS_LOW: ph = PH_START_HI;
            PH_RX_LOW: ph = PH_RX_HIGH;
            PH_RX_HIGH: begin
                shreg = {shreg[6:0], sample};
                if (bidx >= 4'd7) begin
                    p_rv = 1'b1;
                    p_rb = shreg;
                    ph = PH_MACK_LOW;
                end else begin
                    bidx++;
                    ph = PH_RX_LOW;
                end
            end
            PH_MACK_LOW: ph = PH_MACK_HIGH;
            PH_MACK_HIGH: begin
                if (left > 0) left--;
                caddr++;
                if (left == 0) begin
                    ph = PH_STOP_A;
                end else begin
                    bidx = 4'd0;
                    shreg = '0;
                    ph = PH_RX_LOW;
                end
            end
            PH_STOP_A: ph = PH_STOP_B;
            PH_STOP_B: ph = PH_STOP_C;
            PH_STOP_C: begin
                if (!rd_op && err == ST_OK) ph = PH_WAIT;
                else end_xfer(err);
            end
            PH_WAIT: begin
                if (left == 0) begin
                    end_xfer(ST_OK);
                end else begin
                    load_page();
                    role = ROLE_DEV_W;
                    ph = PH_START_HI;
                end
            end
            default: ph = PH_IDLE;
        endcase
    endtask

    // Compute the result of one accepted request
    task automatic predict_result(input t_in it, output t_out r);
        logic [23:0] dur;
        p_done = 1'b0;
        p_st = ST_OK;
        p_rv = 1'b0;
        p_rb = '0;
        if (it.kind == KIND_TICK) begin
            if (ph != PH_IDLE) begin
                dur = (ph == PH_WAIT) ? c_wait : {8'd0, c_half};
                if (dur == '0) dur = 24'd1;
                tcnt = tcnt + 24'd1;
                if (tcnt >= dur) begin
                    tcnt = '0;
                    next_phase(it.sda_sample);
                end
            end
        end else if (ph == PH_IDLE) begin
            if (it.kind == KIND_PUSH) begin
                if (fill < 256) begin
                    wbuf[fill[7:0]] = it.write_byte;
                    fill++;
                    if (fill > written_upto) written_upto = fill;
                end
            end else begin
                rd_op = (it.kind == KIND_READ);
                err = ST_OK;
                tcnt = '0;
                caddr = it.start_address;
                left = int'(it.byte_count);
                role = ROLE_DEV_W;
                bpos = '0;
                if (rd_op) begin
                    if (int'(it.start_address) + int'(it.byte_count) > MEMORY_BYTES)
                        end_xfer(ST_RANGE);
                    else
                        ph = PH_START_HI;
                end else begin
                    fill = 0;
                    if (it.byte_count == '0) begin
                        end_xfer(ST_OK);
                    end else begin
                        load_page();
                        ph = PH_START_HI;
                    end
                end
            end
        end
        r.scl_level = 1'b1;
        r.sda_level = 1'b1;
        case (ph)
            PH_START_LO: r.sda_level = 1'b0;
            PH_TX_LOW: begin
                r.scl_level = 1'b0;
                r.sda_level = shreg[7];
            end
            PH_TX_HIGH: r.sda_level = shreg[7];
            PH_ACK_LOW, PH_RS_LOW, PH_RX_LOW: r.scl_level = 1'b0;
            PH_MACK_LOW: begin
                r.scl_level = 1'b0;
                r.sda_level = (left > 1) ? 1'b0 : 1'b1;
            end
            PH_MACK_HIGH: r.sda_level = (left > 1) ? 1'b0 : 1'b1;
            PH_STOP_A: begin
                r.scl_level = 1'b0;
                r.sda_level = 1'b0;
            end
            PH_STOP_B: r.sda_level = 1'b0;
            default: ;
        endcase
        r.read_valid = p_rv;
        r.read_byte = p_rv ? p_rb : 8'd0;
        r.busy_res = (ph != PH_IDLE);
        r.done_res = p_done;
        r.status = p_done ? p_st : ST_OK;
    endtask

    // Accept requests into the prediction, check results against the oldest one
    always @(posedge i_clk) begin
        t_out want;
        took = 1'b0;
        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                took = 1'b1;
                predict_result(i_data, want);
                expected_res.push_back(want);
            end
            if (o_valid && !i_stall) begin
                if (expected_res.size() == 0) begin
                    $display("unexpected result at %0t", $realtime);
                    fail_count++;
                end else begin
                    want = expected_res.pop_front();
                    if (o_data.scl_level !== want.scl_level)
                        report("scl_level", 8'(o_data.scl_level), 8'(want.scl_level));
                    if (o_data.sda_level !== want.sda_level)
                        report("sda_level", 8'(o_data.sda_level), 8'(want.sda_level));
                    if (o_data.read_valid !== want.read_valid)
                        report("read_valid", 8'(o_data.read_valid), 8'(want.read_valid));
                    if (o_data.read_byte !== want.read_byte)
                        report("read_byte", o_data.read_byte, want.read_byte);
                    if (o_data.busy_res !== want.busy_res)
                        report("busy_res", 8'(o_data.busy_res), 8'(want.busy_res));
                    if (o_data.done_res !== want.done_res)
                        report("done_res", 8'(o_data.done_res), 8'(want.done_res));
                    if (o_data.status !== want.status)
                        report("status", 8'(o_data.status), 8'(want.status));
                end
            end
        end
    end

    // Drive requests; hold the current one until accepted
    always @(negedge i_clk) begin
        bit         nv;
        bit         scan;
        t_in        nd;
        t_pending   head;
        if (i_rst_n && !(i_valid && !took)) begin
            nv = 1'b0;
            nd = i_data;
            scan = (pending_req.size() != 0) && ($urandom_range(0, 99) >= snd_idle_pct);
            while (scan && pending_req.size() != 0) begin
                head = pending_req[0];
                if (head.mode == M_HOLD) begin
                    if (expected_res.size() == 0) void'(pending_req.pop_front());
                    else scan = 1'b0;
                end else if (head.mode == M_RUN && ph == PH_IDLE) begin
                    void'(pending_req.pop_front());
                end else begin
                    if (head.mode == M_RUN) begin
                        nd = t_in'(28'($urandom));
                        nd.kind = KIND_TICK;
                    end else begin
                        void'(pending_req.pop_front());
                        nd = head.req;
                    end
                    if (head.mode != M_FIXED) begin
                        // Bus responder: acknowledge nearly always, random read data
                        if (nd.kind == KIND_TICK && ph == PH_ACK_HIGH)
                            nd.sda_sample = ($urandom_range(0, 59) == 0);
                        if (nd.kind == KIND_WRITE && int'(nd.byte_count) > written_upto)
                            nd.byte_count = written_upto[8:0];
                    end
                    nv = 1'b1;
                    scan = 1'b0;
                end
            end
            i_valid <= nv;
            i_data <= nd;
        end
        i_stall <= ($urandom_range(0, 99) < rcv_idle_pct);
    end

    task automatic add_req(input logic [1:0] kind, input logic [7:0] addr,
                           input logic [8:0] cnt, input logic [7:0] wb,
                           input logic [1:0] mode);
        t_pending p;
        p.req = t_in'(28'($urandom));
        p.req.kind = kind;
        p.req.start_address = addr;
        p.req.byte_count = cnt;
        p.req.write_byte = wb;
        p.mode = mode;
        pending_req.push_back(p);
    endtask

    task automatic run_idle();
        add_req(KIND_TICK, 8'd0, 9'd0, 8'd0, M_RUN);
    endtask

    // Wait until the block has nothing in flight
    task automatic drain();
        while (pending_req.size() != 0 || i_valid || expected_res.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic reg_write(input logic [1:0] idx, input logic [31:0] val);
        @(negedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_HALF: c_half = val[15:0];
            REG_WAIT: c_wait = val[23:0];
            default:  c_dev = val[6:0];
        endcase
    endtask

    task automatic configure(input logic [15:0] h, input logic [23:0] w, input logic [6:0] d);
        drain();
        reg_write(REG_HALF, {16'd0, h});
        reg_write(REG_WAIT, {8'd0, w});
        reg_write(REG_DEV, {25'd0, d});
    endtask

    // One random transaction, mostly well formed
    task automatic random_xfer();
        int sel;
        int n;
        logic [7:0] a;
        sel = $urandom_range(0, 99);
        a = 8'($urandom);
        if (sel < 25) begin
            n = $urandom_range(1, 12);
            repeat (n) add_req(KIND_PUSH, a, 9'd0, 8'($urandom), M_AUTO);
        end else if (sel < 50) begin
            add_req(KIND_WRITE, a, 9'($urandom_range(0, 12)), 8'd0, M_AUTO);
            run_idle();
        end else if (sel < 75) begin
            if ($urandom_range(0, 9) == 0) begin
                // Out of range: start plus count just past the end or further
                if (a == 8'd0) a = 8'd1;
                add_req(KIND_READ, a, 9'($urandom_range(257 - int'(a), 256)), 8'd0, M_AUTO);
            end else begin
                add_req(KIND_READ, a, 9'($urandom_range(0, (256 - a < 6) ? 256 - a : 6)),
                        8'd0, M_AUTO);
            end
            run_idle();
        end else if (sel < 92) begin
            // Commands and pushes arriving during a transfer, raw ticks
            add_req(KIND_READ, a >> 1, 9'($urandom_range(1, 3)), 8'd0, M_AUTO);
            n = $urandom_range(1, 8);
            repeat (n) add_req(2'($urandom), 8'($urandom), 9'($urandom_range(0, 15)),
                               8'($urandom), M_FIXED);
            run_idle();
        end else begin
            add_req(KIND_PUSH, a, 9'd0, 8'($urandom), M_AUTO);
            add_req(KIND_TICK, 8'd0, 9'd0, 8'd0, M_HOLD);
        end
    endtask

    task automatic random_phase(input int n);
        repeat (n) random_xfer();
    endtask

    initial begin
        fail_count = 0;
        snd_idle_pct = 38;
        rcv_idle_pct = 62;
        c_half = 16'd60;
        c_wait = 24'd6000;
        c_dev = 7'd80;
        fill = 0;
        written_upto = 0;
        ph = PH_IDLE;
        bidx = '0;
        shreg = '0;
        caddr = '0;
        left = 0;
        pleft = 0;
        tcnt = '0;
        rd_op = 1'b0;
        role = ROLE_DEV_W;
        bpos = '0;
        err = ST_OK;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_data = '0;
        i_stall = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Reset defaults: pushes, zero-length write, out-of-range reads, idle tick
        add_req(KIND_PUSH, 8'd0, 9'd0, 8'h00, M_AUTO);
        add_req(KIND_PUSH, 8'd0, 9'd0, 8'hFF, M_AUTO);
        add_req(KIND_WRITE, 8'd9, 9'd0, 8'd0, M_AUTO);
        add_req(KIND_READ, 8'd250, 9'd7, 8'd0, M_AUTO);
        add_req(KIND_READ, 8'd1, 9'd256, 8'd0, M_FIXED);
        add_req(KIND_TICK, 8'd0, 9'd0, 8'd0, M_AUTO);
        add_req(KIND_TICK, 8'd0, 9'd0, 8'd0, M_HOLD);

        // Page-crossing write with address wrap, requests while busy,
        // zero-length read, last-byte read
        configure(16'd1, 24'd2, 7'($urandom));
        add_req(KIND_PUSH, 8'd0, 9'd0, 8'h00, M_AUTO);
        add_req(KIND_PUSH, 8'd0, 9'd0, 8'hFF, M_AUTO);
        add_req(KIND_PUSH, 8'd0, 9'd0, 8'hA5, M_AUTO);
        add_req(KIND_WRITE, 8'hFF, 9'd3, 8'd0, M_AUTO);
        add_req(KIND_PUSH, 8'd0, 9'd0, 8'h11, M_AUTO);
        add_req(KIND_WRITE, 8'd4, 9'd1, 8'd0, M_AUTO);
        run_idle();
        add_req(KIND_READ, 8'd0, 9'd0, 8'd0, M_AUTO);
        run_idle();
        add_req(KIND_READ, 8'd255, 9'd2, 8'd0, M_AUTO);
        add_req(KIND_READ, 8'd255, 9'd1, 8'd0, M_AUTO);
        run_idle();
        add_req(KIND_TICK, 8'd0, 9'd0, 8'd0, M_HOLD);

        configure(16'd0, 24'd0, 7'd0);
        snd_idle_pct = 62;
        rcv_idle_pct = 38;
        random_phase(3);

        // Full buffer, push while full, short write from the full buffer
        configure(16'd0, 24'd3, 7'd127);
        add_req(KIND_WRITE, 8'd0, 9'd0, 8'd0, M_AUTO);
        for (int k = 0; k < 256; k++) add_req(KIND_PUSH, 8'd0, 9'd0, 8'($urandom), M_AUTO);
        add_req(KIND_PUSH, 8'd0, 9'd0, 8'h5A, M_AUTO);
        add_req(KIND_WRITE, 8'($urandom), 9'd2, 8'd0, M_AUTO);
        run_idle();

        // Largest timing values: only requests that finish without bus activity
        configure(16'hFFFF, 24'hFFFFFF, 7'($urandom));
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
        add_req(KIND_PUSH, 8'd0, 9'd0, 8'h3C, M_AUTO);
        add_req(KIND_WRITE, 8'd3, 9'd0, 8'd0, M_AUTO);
        add_req(KIND_READ, 8'd200, 9'd100, 8'd0, M_AUTO);
        add_req(KIND_TICK, 8'd0, 9'd0, 8'd0, M_AUTO);

        configure(16'd1, 24'd1, 7'($urandom));
        random_phase(2);

        drain();
        if (fail_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

### i2c_eeprom_page_controller.f
hw/rtl/iepc_pkg.sv
hw/rtl/iepc_buffer.sv
hw/rtl/iepc_seq.sv
hw/rtl/i2c_eeprom_page_controller.sv
dv/tb_top.sv
